@@ src/dlb_pkg.sv @@
// Shared constants, types and helper functions for the detection row decoder.
// No dependencies; every other file in the block imports this package.
package dlb_pkg;

  localparam int MAX_CLASSES    = 128;
  localparam int MAX_IMAGE_SIZE = 4096;

  localparam int ValueW = 32;
  localparam int ThrW   = 17;
  localparam int CountW = 8;
  localparam int SizeW  = 13;
  localparam int ClassW = 7;
  localparam int CoordW = 14;
  localparam int DimW   = 13;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 17;

  // Quotient width and the widths of the long division operands.
  localparam int QuotW = 14;
  localparam int ProdW = 48;
  localparam int DivW  = 49;
  localparam int PadW  = 2 * SizeW;

  localparam logic [CfgIdxW-1:0] REG_CONF_THR  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SCORE_THR = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CLASSES   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_IMG_W     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_IMG_H     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_NET_W     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_NET_H     = 3'd6;

  localparam logic [1:0] ITEM_LEFT   = 2'd0;
  localparam logic [1:0] ITEM_TOP    = 2'd1;
  localparam logic [1:0] ITEM_WIDTH  = 2'd2;
  localparam logic [1:0] ITEM_HEIGHT = 2'd3;

  typedef struct packed {
    logic       accept;
    logic       setup0;
    logic       setup1;
    logic       mul;
    logic       prep;
    logic       div_step;
    logic       store;
    logic       out_load;
    logic [1:0] item;
  } dlb_cmd_t;

  typedef struct packed {
    logic row_done;
    logic row_keep;
    logic out_busy;
  } dlb_status_t;

  // Sizes of zero count as one; sizes above the limit are capped.
  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v);
    logic [SizeW-1:0] r;
    r = v;
    if (v == '0) r = SizeW'(1);
    else if (v > SizeW'(MAX_IMAGE_SIZE)) r = SizeW'(MAX_IMAGE_SIZE);
    return r;
  endfunction

endpackage

@@ src/dlb_element_if.sv @@
// Element request channel: one row element with its row end mark.
// Depends on dlb_pkg for the field widths.
interface dlb_element_if;
  import dlb_pkg::*;
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] element_value;
  logic              row_end;
  modport source (output valid, element_value, row_end, input ready);
  modport sink   (input valid, element_value, row_end, output ready);
endinterface

@@ src/dlb_result_if.sv @@
// Result request channel: one kept detection with its box in image pixels.
// Depends on dlb_pkg for the field widths.
interface dlb_result_if;
  import dlb_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [ClassW-1:0]        class_index;
  logic [ThrW-1:0]          score;
  logic signed [CoordW-1:0] left;
  logic signed [CoordW-1:0] top;
  logic [DimW-1:0]          box_width;
  logic [DimW-1:0]          box_height;
  modport source (output valid, class_index, score, left, top, box_width, box_height,
                  input ready);
  modport sink   (input valid, class_index, score, left, top, box_width, box_height,
                  output ready);
endinterface

@@ src/dlb_ctrl.sv @@
// Controller state machine: element collection, letterbox setup and the
// shared long division sequence. Depends on dlb_pkg.
module dlb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dlb_pkg::dlb_status_t status,
  output dlb_pkg::dlb_cmd_t    cmd
);
  import dlb_pkg::*;

  localparam logic [2:0] ST_COLLECT = 3'd0;
  localparam logic [2:0] ST_SETUP0  = 3'd1;
  localparam logic [2:0] ST_SETUP1  = 3'd2;
  localparam logic [2:0] ST_MUL     = 3'd3;
  localparam logic [2:0] ST_PREP    = 3'd4;
  localparam logic [2:0] ST_DIV     = 3'd5;
  localparam logic [2:0] ST_STORE   = 3'd6;
  localparam logic [2:0] ST_OUT     = 3'd7;

  logic [2:0] state, state_next;
  logic [3:0] cnt, cnt_next;
  logic [1:0] item, item_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
      cnt   <= '0;
      item  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      item  <= item_next;
    end
  end

  assign in_ready = (state == ST_COLLECT);

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    item_next    = item;
    cmd          = '0;
    cmd.item     = item;
    unique case (state)
      ST_COLLECT: begin
        cmd.accept = in_valid;
        if (in_valid && status.row_done && status.row_keep) begin
          state_next = ST_SETUP0;
        end
      end
      ST_SETUP0: begin
        cmd.setup0 = 1'b1;
        state_next = ST_SETUP1;
      end
      ST_SETUP1: begin
        cmd.setup1 = 1'b1;
        item_next  = ITEM_LEFT;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 4'd1;
        if (cnt == 4'(QuotW - 1)) state_next = ST_STORE;
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (item == ITEM_HEIGHT) begin
          state_next = ST_OUT;
        end else begin
          item_next  = item + 2'd1;
          state_next = ST_MUL;
        end
      end
      ST_OUT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_COLLECT;
        end
      end
      default: state_next = ST_COLLECT;
    endcase
  end

endmodule

@@ src/dlb_datapath.sv @@
// Datapath: configuration registers, row element capture and argmax, the
// letterbox scale and padding, the shared divider and the output register.
// Depends on dlb_pkg.
module dlb_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [dlb_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [dlb_pkg::CfgDataW-1:0]    cfg_data,
  input  logic [dlb_pkg::ValueW-1:0]      element_value,
  input  logic                            row_end,
  input  dlb_pkg::dlb_cmd_t               cmd,
  output dlb_pkg::dlb_status_t            status,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [dlb_pkg::ClassW-1:0]      class_index,
  output logic [dlb_pkg::ThrW-1:0]        score,
  output logic signed [dlb_pkg::CoordW-1:0] left,
  output logic signed [dlb_pkg::CoordW-1:0] top,
  output logic [dlb_pkg::DimW-1:0]        box_width,
  output logic [dlb_pkg::DimW-1:0]        box_height
);
  import dlb_pkg::*;

  logic [ThrW-1:0]   conf_thr, score_thr;
  logic [CountW-1:0] class_count;
  logic [SizeW-1:0]  img_w, img_h, net_w, net_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      conf_thr    <= ThrW'(32768);
      score_thr   <= ThrW'(32768);
      class_count <= CountW'(80);
      img_w       <= SizeW'(640);
      img_h       <= SizeW'(640);
      net_w       <= SizeW'(640);
      net_h       <= SizeW'(640);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CONF_THR:  conf_thr    <= cfg_data;
        REG_SCORE_THR: score_thr   <= cfg_data;
        REG_CLASSES:   class_count <= cfg_data[CountW-1:0];
        REG_IMG_W:     img_w       <= cfg_data[SizeW-1:0];
        REG_IMG_H:     img_h       <= cfg_data[SizeW-1:0];
        REG_NET_W:     net_w       <= cfg_data[SizeW-1:0];
        REG_NET_H:     net_h       <= cfg_data[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // Row element capture and running argmax.
  logic [CountW-1:0] pos;
  logic [ValueW-1:0] box [4];
  logic [ValueW-1:0] objectness;
  logic [ValueW-1:0] best_score;
  logic [ClassW-1:0] best_class;
  logic [CountW-1:0] eff_classes, cls_off;
  logic              is_class, better;
  logic [ValueW-1:0] obj_now, best_now;
  logic [ClassW-1:0] class_now;

  always_comb begin
    eff_classes = class_count;
    if (class_count == '0) eff_classes = CountW'(1);
    else if (class_count > CountW'(MAX_CLASSES)) eff_classes = CountW'(MAX_CLASSES);
    cls_off   = pos - CountW'(5);
    is_class  = (pos >= CountW'(5)) && (cls_off < eff_classes);
    better    = is_class && (element_value > best_score);
    obj_now   = (pos == CountW'(4)) ? element_value : objectness;
    best_now  = better ? element_value : best_score;
    class_now = better ? cls_off[ClassW-1:0] : best_class;
  end

  assign status.row_done = row_end;
  assign status.row_keep = (obj_now >= ValueW'(conf_thr)) && (best_now > ValueW'(score_thr));

  logic [ClassW-1:0] pend_class;
  logic [ThrW-1:0]   pend_score;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      best_score <= '0;
      best_class <= '0;
    end else if (cmd.accept) begin
      if (row_end) begin
        pos        <= '0;
        best_score <= '0;
        best_class <= '0;
      end else begin
        if (pos != '1) pos <= pos + CountW'(1);
        best_score <= best_now;
        best_class <= class_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (pos < CountW'(4)) box[pos[1:0]] <= element_value;
      if (pos == CountW'(4)) objectness <= element_value;
      pend_class <= class_now;
      pend_score <= (obj_now > ValueW'(65536)) ? ThrW'(65536) : obj_now[ThrW-1:0];
    end
  end

  // Letterbox scale as the ratio sn/sd, padding kept doubled and scaled by sd.
  logic [SizeW-1:0] c_iw, c_ih, c_nw, c_nh;
  logic [PadW-1:0]  p_hw, p_wh;
  logic [SizeW-1:0] sn, sd;
  logic [PadW-1:0]  padx2, pady2;

  always_ff @(posedge clk) begin
    if (cmd.setup0) begin
      c_iw <= clamp_size(img_w);
      c_ih <= clamp_size(img_h);
      c_nw <= clamp_size(net_w);
      c_nh <= clamp_size(net_h);
    end
    if (cmd.setup1) begin
      if (p_hw > p_wh) begin
        sn    <= c_nw;
        sd    <= c_iw;
        padx2 <= '0;
        pady2 <= p_hw - p_wh;
      end else begin
        sn    <= c_nh;
        sd    <= c_ih;
        padx2 <= p_wh - p_hw;
        pady2 <= '0;
      end
    end
  end

  assign p_hw = c_nh * c_iw;
  assign p_wh = c_nw * c_ih;

  // Numerator of one box value, scaled by the scale denominator.
  logic signed [ValueW+1:0] term;
  logic signed [ProdW-1:0]  prod;

  always_comb begin
    if (cmd.item == ITEM_LEFT || cmd.item == ITEM_TOP) begin
      term = $signed({1'b0, box[cmd.item], 1'b0}) - $signed({2'b00, box[cmd.item + 2'd2]});
    end else begin
      term = $signed({1'b0, box[cmd.item], 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) prod <= term * $signed({1'b0, sd});
  end

  // Rounding divide: q = floor((|n| + sn*2^16) / (sn*2^17)), one bit a cycle.
  logic [PadW-1:0]         pad_sel;
  logic signed [ProdW-1:0] num;
  logic [ProdW-1:0]        mag;
  logic [DivW-1:0]         x_init, x_rem, dsh;
  logic                    neg, sat;
  logic [QuotW-1:0]        quo;

  always_comb begin
    case (cmd.item)
      ITEM_LEFT: pad_sel = padx2;
      ITEM_TOP:  pad_sel = pady2;
      default:   pad_sel = '0;
    endcase
    num    = prod - $signed({6'b0, pad_sel, 16'b0});
    mag    = num[ProdW-1] ? ProdW'(-num) : ProdW'(num);
    x_init = {1'b0, mag} + {20'b0, sn, 16'b0};
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      neg   <= num[ProdW-1];
      x_rem <= x_init;
      sat   <= x_init >= {5'b0, sn, 31'b0};
      dsh   <= {6'b0, sn, 30'b0};
      quo   <= '0;
    end else if (cmd.div_step) begin
      if (x_rem >= dsh) begin
        x_rem <= x_rem - dsh;
        quo   <= {quo[QuotW-2:0], 1'b1};
      end else begin
        quo   <= {quo[QuotW-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  logic signed [CoordW-1:0] res [4];
  logic signed [CoordW-1:0] final_val;

  always_comb begin
    if (neg) begin
      if (sat || quo > QuotW'(8192)) final_val = CoordW'(-8192);
      else final_val = -$signed(quo);
    end else begin
      if (sat || quo > QuotW'(8191)) final_val = CoordW'(8191);
      else final_val = $signed(quo);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) res[cmd.item] <= final_val;
  end

  // Output register; the controller only loads it once the old result is gone.
  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      class_index <= pend_class;
      score       <= pend_score;
      left        <= res[ITEM_LEFT];
      top         <= res[ITEM_TOP];
      box_width   <= res[ITEM_WIDTH][DimW-1:0];
      box_height  <= res[ITEM_HEIGHT][DimW-1:0];
    end
  end

endmodule

@@ src/detection_row_decode_letterbox.sv @@
// Top level of the detection row decoder with letterbox mapping.
// Depends on dlb_pkg, dlb_element_if, dlb_result_if, dlb_ctrl and dlb_datapath.
//
//  Channel     | Direction | Carries
//  ------------+-----------+------------------------------------------------
//  element_in  | sink      | element_value (Q16.16), row_end
//  result_out  | source    | class_index, score, left, top, box_width, box_height
//  cfg_*       | sink      | register writes, index and data, no read-back
//
// Elements are taken one per cycle while a row is being collected. A row end
// that keeps the detection holds the input off for the letterbox scale and
// padding setup, then for each of the four box values one multiply, one
// preparation, fourteen steps of the shared bit-serial divider and one
// store, and finally the load of the output register. Rows that are dropped
// do not hold the input off. The finished result sits in an output
// register, so the next row is collected while it waits; only a second kept
// row stalls until the first request has been taken.
// Reset is synchronous and restores the register defaults.
module detection_row_decode_letterbox (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [dlb_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [dlb_pkg::CfgDataW-1:0] cfg_data,
  dlb_element_if.sink                  element_in,
  dlb_result_if.source                 result_out
);
  import dlb_pkg::*;

  dlb_cmd_t    cmd;
  dlb_status_t status;

  // The controller sequences collection, setup and the division steps.
  dlb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (element_in.valid),
    .in_ready (element_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the row state, the arithmetic and the result register.
  dlb_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .element_value (element_in.element_value),
    .row_end       (element_in.row_end),
    .cmd           (cmd),
    .status        (status),
    .out_ready     (result_out.ready),
    .out_valid     (result_out.valid),
    .class_index   (result_out.class_index),
    .score         (result_out.score),
    .left          (result_out.left),
    .top           (result_out.top),
    .box_width     (result_out.box_width),
    .box_height    (result_out.box_height)
  );

endmodule
